// ===== rtl/core/pipg_pkg.sv =====
// Shared types and constants for the point-in-polygon geofence.
// Field widths, stream packing layout, command codes and sequencer states.
// No dependencies.
package pipg_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MIN_POLY_VERTICES = 3;

    localparam int CFG_W = 7;
    localparam int IDX_W = 6;
    localparam int LAT_W = 31;
    localparam int LON_W = 32;
    localparam int CNT_W = 7;

    // input tdata layout, lowest bit first
    localparam int IDX_LSB  = 0;
    localparam int LAT_LSB  = IDX_LSB + IDX_W;
    localparam int LON_LSB  = LAT_LSB + LAT_W;
    localparam int WANT_BIT = LON_LSB + LON_W;
    localparam int S_TDATA_W = ((WANT_BIT + 1 + 7) / 8) * 8;

    // output tdata layout
    localparam int M_TDATA_W = 16;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } pipg_cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } pipg_state_t;

endpackage

// ===== rtl/core/point_in_polygon_geofence.sv =====
// Geofence: vertex store plus ray-casting crossing counter over a shared edge unit.
// Depends on pipg_pkg (widths, packing, command codes, states).
// Operation: a vertex write is stored on acceptance; a query with n = min(vertex_count, MAX_VERTICES)
// of at least 3 walks n+1 entries through the edge pipeline and loads its result once it drains,
// fewer than 3 goes straight to the result. Queries do not overlap: s_tready stays low from
// acceptance until the result is loaded, as the single vertex-store read port walks the entries;
// writes stream at one per cycle while no query is in progress.
// Reset (rst_n low, asynchronous): vertex_count clears to 0, sequencer idle, no result
// pending; the vertex store is not cleared and reads back undefined until written.
module point_in_polygon_geofence
#(
    parameter int MAX_VERTICES = pipg_pkg::MAX_VERTICES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    // configuration write channel: vertex_count
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pipg_pkg::CFG_W-1:0]     cfg_data,

    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata from bit 0: vertex_index[5:0], latitude[30:0], longitude[31:0],
    // want_outside, zero fill
    input  logic [pipg_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: command (0 = write vertex, 1 = query point)
    input  logic [0:0]                     s_tuser,

    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata from bit 0: matches_res, inside_res, crossings[6:0], zero fill
    output logic [pipg_pkg::M_TDATA_W-1:0] m_tdata
);

    import pipg_pkg::*;

    localparam int AW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NCLAMP = (MAX_VERTICES > 127) ? 127 : MAX_VERTICES;
    localparam int VTX_W  = LAT_W + LON_W;

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]        in_idx;
    logic signed [LAT_W-1:0] in_lat;
    logic signed [LON_W-1:0] in_lon;
    logic                    in_want;

    assign in_idx  = s_tdata[IDX_LSB +: IDX_W];
    assign in_lat  = s_tdata[LAT_LSB +: LAT_W];
    assign in_lon  = s_tdata[LON_LSB +: LON_W];
    assign in_want = s_tdata[WANT_BIT];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    pipg_state_t state_reg, state_next;

    logic [CFG_W-1:0] vcount_reg;     // configured vertex_count
    logic [CFG_W-1:0] n_reg;          // clamped vertex count of the active query
    logic [CFG_W-1:0] rd_cnt_reg;     // store reads issued so far
    logic             short_reg;      // polygon has fewer than three vertices

    logic signed [LAT_W-1:0] q_lat_reg;
    logic signed [LON_W-1:0] q_lon_reg;
    logic                    want_reg;

    // vertex store, one read port with registered data
    logic [VTX_W-1:0] vtx_mem [MAX_VERTICES];
    logic [VTX_W-1:0] mem_q_reg;
    logic             rd_v_reg;
    logic             rd_first_reg;

    logic signed [LAT_W-1:0] prev_lat_reg;
    logic signed [LON_W-1:0] prev_lon_reg;

    // edge unit stage 1: differences and band test
    logic                    e_v_reg;
    logic                    e_band_reg;
    logic signed [LON_W:0]   e_dlonq_reg;   // lon1 - qlon
    logic signed [LAT_W:0]   e_den_reg;     // lat1 - lat2
    logic signed [LON_W:0]   e_dlon_reg;    // lon1 - lon2
    logic signed [LAT_W:0]   e_dlatq_reg;   // lat1 - qlat

    // edge unit stage 2: cross products
    localparam int PROD_W = LON_W + LAT_W + 2;
    logic                     p_v_reg;
    logic                     p_band_reg;
    logic                     p_neg_reg;
    logic signed [PROD_W-1:0] p_lhs_reg;
    logic signed [PROD_W-1:0] p_rhs_reg;

    logic [CNT_W-1:0] count_reg;

    logic                 m_tvalid_reg;
    logic [CNT_W+1:0]     out_reg;   // {crossings, inside_res, matches_res}

    // ------------------------------------------------------------------
    // Sequencer control
    // ------------------------------------------------------------------
    logic             s_fire;
    logic             is_query;
    logic             wr_en;
    logic             rd_issue;
    logic             out_load;
    logic [CFG_W-1:0] n_clamped;
    logic [AW-1:0]    rd_addr;

    assign s_fire   = s_tvalid && s_tready;
    assign is_query = (s_tuser == CMD_QUERY);
    assign wr_en    = s_fire && !is_query && (int'(in_idx) < MAX_VERTICES);

    assign n_clamped = (vcount_reg > CFG_W'(NCLAMP)) ? CFG_W'(NCLAMP) : vcount_reg;

    // closing edge wraps the last read back to entry zero
    assign rd_addr = (rd_cnt_reg == n_reg) ? '0 : AW'(rd_cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && is_query)
                begin
                    if (n_clamped < CFG_W'(MIN_POLY_VERTICES))
                        state_next = ST_DONE;
                    else
                        state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (rd_cnt_reg == n_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // wait for the last edge to leave the pipeline
                if (!rd_v_reg && !e_v_reg && !p_v_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        rd_issue = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_WALK:  rd_issue = 1'b1;
            ST_DRAIN: ;
            ST_DONE:  out_load = !m_tvalid_reg || m_tready;
            default:  ;
        endcase
    end

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            vcount_reg   <= '0;
            rd_cnt_reg   <= '0;
            rd_v_reg     <= 1'b0;
            rd_first_reg <= 1'b0;
            e_v_reg      <= 1'b0;
            p_v_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
                vcount_reg <= cfg_data;

            if (s_fire)
                rd_cnt_reg <= '0;
            else if (rd_issue)
                rd_cnt_reg <= rd_cnt_reg + 1'b1;

            rd_v_reg     <= rd_issue;
            rd_first_reg <= rd_issue && (rd_cnt_reg == '0);
            // the first read only primes the previous-vertex register
            e_v_reg      <= rd_v_reg && !rd_first_reg;
            p_v_reg      <= e_v_reg;

            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Vertex store
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
            vtx_mem[AW'(in_idx)] <= {in_lon, in_lat};
        if (rd_issue)
            mem_q_reg <= vtx_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Query capture and edge pipeline
    // ------------------------------------------------------------------
    logic signed [LAT_W-1:0] cur_lat;
    logic signed [LON_W-1:0] cur_lon;
    logic                    band;
    logic                    crossed;

    assign cur_lat = mem_q_reg[LAT_W-1:0];
    assign cur_lon = mem_q_reg[VTX_W-1:LAT_W];

    // half-open latitude band; an empty band also rules out horizontal edges
    assign band = ((q_lat_reg >= prev_lat_reg) && (q_lat_reg < cur_lat)) ||
                  ((q_lat_reg >= cur_lat) && (q_lat_reg < prev_lat_reg));

    // compare sense flips with the sign of the denominator
    assign crossed = p_band_reg &&
                     (p_neg_reg ? (p_lhs_reg > p_rhs_reg) : (p_lhs_reg < p_rhs_reg));

    always_ff @(posedge clk)
    begin
        if (s_fire && is_query)
        begin
            q_lat_reg <= in_lat;
            q_lon_reg <= in_lon;
            want_reg  <= in_want;
            n_reg     <= n_clamped;
            short_reg <= (n_clamped < CFG_W'(MIN_POLY_VERTICES));
            count_reg <= '0;
        end
        else if (p_v_reg && crossed)
        begin
            count_reg <= count_reg + 1'b1;
        end

        if (rd_v_reg)
        begin
            prev_lat_reg <= cur_lat;
            prev_lon_reg <= cur_lon;
        end

        // stage 1: operand differences
        e_band_reg  <= band;
        e_dlonq_reg <= {prev_lon_reg[LON_W-1], prev_lon_reg} - {q_lon_reg[LON_W-1], q_lon_reg};
        e_den_reg   <= {prev_lat_reg[LAT_W-1], prev_lat_reg} - {cur_lat[LAT_W-1], cur_lat};
        e_dlon_reg  <= {prev_lon_reg[LON_W-1], prev_lon_reg} - {cur_lon[LON_W-1], cur_lon};
        e_dlatq_reg <= {prev_lat_reg[LAT_W-1], prev_lat_reg} - {q_lat_reg[LAT_W-1], q_lat_reg};

        // stage 2: cross-multiply
        p_band_reg <= e_band_reg;
        p_neg_reg  <= e_den_reg[LAT_W];
        p_lhs_reg  <= PROD_W'(e_dlonq_reg * e_den_reg);
        p_rhs_reg  <= PROD_W'(e_dlon_reg * e_dlatq_reg);

        // result register
        if (out_load)
        begin
            if (short_reg)
                out_reg <= '0;
            else
                out_reg <= {count_reg, count_reg[0], count_reg[0] ^ want_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

endmodule
